/* rtl/sqvt_pkg.sv */
package sqvt_pkg;

    localparam int ANGLE_HALF  = 23040;
    localparam int ANGLE_SHIFT = 10;
    localparam int ANGLE_DIV   = 45;
    localparam int RECIP_DIV   = 372827;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 24;
    localparam int ROUND_HALF  = 2097152;
    localparam int ROUND_SHIFT = 22;

    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic signed [23:0] POS_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] POS_MIN = 24'sh80_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] FRAC_MASK   = 64'h3FFF_FFFF;

    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

    typedef struct packed {
        logic signed [36:0] x0;
        logic signed [36:0] y0;
        logic signed [36:0] sw;
        logic signed [36:0] sh;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [11:0]        tex_left;
        logic [11:0]        tex_top;
        logic [11:0]        tex_width;
        logic [11:0]        tex_height;
        logic [31:0]        color;
    } geo_t;

    typedef struct packed {
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
        geo_t               geo;
    } job_t;

    typedef struct packed {
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [12:0]        tex_u;
        logic [12:0]        tex_v;
        logic [31:0]        vert_color;
        logic [1:0]         corner;
        logic               last;
    } vert_t;

    // Magnitude of one quarter-wave entry in Q1.14, evaluated at elaboration.
    function automatic logic [14:0] rom_mag(input int unsigned step,
                                            input int unsigned tbits,
                                            input logic want_cos);
        logic [63:0]        ph;
        logic [63:0]        theta;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        ph    = 64'(step) << (32 - tbits);
        theta = ((ph & FRAC_MASK) * HALF_PI_Q30) >> 30;
        x2    = (theta * theta) >> 30;
        term  = want_cos ? Q30_ONE : theta;
        sum   = $signed(term);
        for (int k = 0; k < 7; k++)
        begin
            term = (term * x2) >> 30;
            term = want_cos ? (term / COS_DIV[k]) : (term / SIN_DIV[k]);
            if ((k & 1) == 0)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 64'sd0)
        begin
            sum = 64'sd0;
        end
        if (sum > $signed(Q30_ONE))
        begin
            sum = $signed(Q30_ONE);
        end
        q = (sum + 64'sd32768) >>> 16;
        if (q > 64'sd16384)
        begin
            q = 64'sd16384;
        end
        return q[14:0];
    endfunction

endpackage

/* rtl/sprite_quad_vertex_transform_top.sv */
// Path: an accepted sprite passes the front stages f1 to f3, the job queue, the back stages
// b1 to b3 and the output queue; the other three corners follow the first while pop is held.
// Throughput: one corner per cycle while the output queue has room, set by the corner
// sequencer of the rotate stage, which takes a new sprite only after the last corner of the one before.
// Reset: rst_n clears all queues and pipeline valid bits; the sine table is constant
// logic and the block takes sprites as soon as reset is released.
module sprite_quad_vertex_transform_top #(
    parameter int TABLE_SIZE = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic [11:0]        tex_left,
    input  logic [11:0]        tex_top,
    input  logic [11:0]        tex_width,
    input  logic [11:0]        tex_height,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [20:0] origin_x,
    input  logic signed [20:0] origin_y,
    input  logic [15:0]        rotation,
    input  logic [31:0]        color,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] vert_x,
    output logic signed [23:0] vert_y,
    output logic [12:0]        tex_u,
    output logic [12:0]        tex_v,
    output logic [31:0]        vert_color,
    output logic [1:0]         corner,
    output logic               last
);

    sqvt_pkg::job_t  front_job;
    sqvt_pkg::job_t  back_job;
    sqvt_pkg::vert_t back_item;
    sqvt_pkg::vert_t out_item;
    logic            front_valid;
    logic            jobq_full;
    logic            jobq_empty;
    logic            job_pop;
    logic            back_valid;
    logic            outq_full;

    sqvt_front #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .tex_left  (tex_left),
        .tex_top   (tex_top),
        .tex_width (tex_width),
        .tex_height(tex_height),
        .scale_x   (scale_x),
        .scale_y   (scale_y),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .rotation  (rotation),
        .color     (color),
        .job_valid (front_valid),
        .job_ready (!jobq_full),
        .job       (front_job)
    );

    sqvt_fifo #(
        .WIDTH($bits(sqvt_pkg::job_t)),
        .DEPTH(sqvt_pkg::JOB_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_valid),
        .full   (jobq_full),
        .wr_data(front_job),
        .pop    (job_pop),
        .empty  (jobq_empty),
        .rd_data(back_job)
    );

    sqvt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(!jobq_empty),
        .job_pop  (job_pop),
        .job      (back_job),
        .out_valid(back_valid),
        .out_ready(!outq_full),
        .out_item (back_item)
    );

    sqvt_fifo #(
        .WIDTH($bits(sqvt_pkg::vert_t)),
        .DEPTH(sqvt_pkg::OUT_DEPTH)
    ) u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (back_valid),
        .full   (outq_full),
        .wr_data(back_item),
        .pop    (pop),
        .empty  (empty),
        .rd_data(out_item)
    );

    assign vert_x     = out_item.vert_x;
    assign vert_y     = out_item.vert_y;
    assign tex_u      = out_item.tex_u;
    assign tex_v      = out_item.tex_v;
    assign vert_color = out_item.vert_color;
    assign corner     = out_item.corner;
    assign last       = out_item.last;

endmodule

/* rtl/sqvt_fifo.sv */
module sqvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr != do_rd |=> count_reg != $past(count_reg))
        else $error("queue count did not follow a push or pop");

endmodule

/* rtl/sqvt_sine_rom.sv */
module sqvt_sine_rom #(
    parameter int TABLE_SIZE = 512
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [$clog2(TABLE_SIZE)-3:0] addr,
    output logic [14:0]                   sin_mag,
    output logic [14:0]                   cos_mag
);

    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int QUARTER    = TABLE_SIZE / 4;

    logic [14:0] sin_rom [QUARTER];
    logic [14:0] cos_rom [QUARTER];

    for (genvar g = 0; g < QUARTER; g++)
    begin : g_rom
        localparam logic [14:0] SIN_V = sqvt_pkg::rom_mag(g, TABLE_BITS, 1'b0);
        localparam logic [14:0] COS_V = sqvt_pkg::rom_mag(g, TABLE_BITS, 1'b1);
        assign sin_rom[g] = SIN_V;
        assign cos_rom[g] = COS_V;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag <= sin_rom[addr];
            cos_mag <= cos_rom[addr];
        end
    end

endmodule

/* rtl/sqvt_front.sv */
module sqvt_front #(
    parameter int TABLE_SIZE = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic [11:0]        tex_left,
    input  logic [11:0]        tex_top,
    input  logic [11:0]        tex_width,
    input  logic [11:0]        tex_height,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic signed [20:0] origin_x,
    input  logic signed [20:0] origin_y,
    input  logic [15:0]        rotation,
    input  logic [31:0]        color,
    output logic               job_valid,
    input  logic               job_ready,
    output sqvt_pkg::job_t     job
);

    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int SUM_W      = 17 + TABLE_BITS;
    localparam int T_W        = SUM_W - sqvt_pkg::ANGLE_SHIFT;
    localparam int PROD_W     = T_W + sqvt_pkg::RECIP_W;
    localparam int QE_W       = PROD_W - sqvt_pkg::RECIP_SHIFT;

    logic f1_v_reg;
    logic f1_v_next;
    logic f2_v_reg;
    logic f2_v_next;
    logic f3_v_reg;
    logic f3_v_next;
    logic f1_ready;
    logic f2_ready;
    logic f3_ready;

    sqvt_pkg::geo_t    geo_next;
    sqvt_pkg::geo_t    f1_geo_reg;
    sqvt_pkg::geo_t    f2_geo_reg;
    sqvt_pkg::geo_t    f3_geo_reg;
    logic [T_W-1:0]    f1_t_reg;
    logic [T_W-1:0]    t_next;
    logic [PROD_W-1:0] f1_prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [TABLE_BITS-1:0] f2_idx_reg;
    logic [TABLE_BITS-1:0] idx_next;
    logic [1:0]        f3_quad_reg;

    logic [SUM_W-1:0]  rot_sum;
    logic [QE_W-1:0]   q_est;
    logic [T_W-1:0]    rem;
    logic signed [36:0] ox_sx;
    logic signed [36:0] oy_sy;
    logic signed [28:0] w_sx;
    logic signed [28:0] h_sy;
    logic [14:0]       sin_mag;
    logic [14:0]       cos_mag;
    logic [14:0]       sin_sel;
    logic [14:0]       cos_sel;

    assign f3_ready  = !f3_v_reg || job_ready;
    assign f2_ready  = !f2_v_reg || f3_ready;
    assign f1_ready  = !f1_v_reg || f2_ready;
    assign full      = !f1_ready;
    assign f1_v_next = f1_ready ? push : f1_v_reg;
    assign f2_v_next = f2_ready ? f1_v_reg : f2_v_reg;
    assign f3_v_next = f3_ready ? f2_v_reg : f3_v_reg;

    // Angle step: floor((rotation * TABLE_SIZE + 23040) / 46080), done as a
    // shift right by 10 bits (a divide by 1024) and a reciprocal multiply by 1/45 with one correction step.
    assign rot_sum   = {1'b0, rotation, {TABLE_BITS{1'b0}}}
                       + SUM_W'(sqvt_pkg::ANGLE_HALF);
    assign t_next    = rot_sum[SUM_W-1:sqvt_pkg::ANGLE_SHIFT];
    assign prod_next = PROD_W'(t_next) * PROD_W'(sqvt_pkg::RECIP_DIV);

    assign q_est    = f1_prod_reg[PROD_W-1:sqvt_pkg::RECIP_SHIFT];
    assign rem      = f1_t_reg - T_W'(q_est) * T_W'(sqvt_pkg::ANGLE_DIV);
    assign idx_next = TABLE_BITS'(q_est)
                      + TABLE_BITS'(rem >= T_W'(sqvt_pkg::ANGLE_DIV));

    assign ox_sx = origin_x * scale_x;
    assign oy_sy = origin_y * scale_y;
    assign w_sx  = $signed({1'b0, tex_width}) * scale_x;
    assign h_sy  = $signed({1'b0, tex_height}) * scale_y;

    always_comb
    begin
        geo_next.x0         = -ox_sx;
        geo_next.y0         = -oy_sy;
        geo_next.sw         = $signed({w_sx, 8'h00});
        geo_next.sh         = $signed({h_sy, 8'h00});
        geo_next.px         = pos_x;
        geo_next.py         = pos_y;
        geo_next.tex_left   = tex_left;
        geo_next.tex_top    = tex_top;
        geo_next.tex_width  = tex_width;
        geo_next.tex_height = tex_height;
        geo_next.color      = color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= f1_v_next;
            f2_v_reg <= f2_v_next;
            f3_v_reg <= f3_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_ready && push)
        begin
            f1_geo_reg  <= geo_next;
            f1_t_reg    <= t_next;
            f1_prod_reg <= prod_next;
        end
        if (f2_ready && f1_v_reg)
        begin
            f2_geo_reg <= f1_geo_reg;
            f2_idx_reg <= idx_next;
        end
        if (f3_ready && f2_v_reg)
        begin
            f3_geo_reg  <= f2_geo_reg;
            f3_quad_reg <= f2_idx_reg[TABLE_BITS-1 -: 2];
        end
    end

    sqvt_sine_rom #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_rom (
        .clk    (clk),
        .en     (f3_ready && f2_v_reg),
        .addr   (f2_idx_reg[TABLE_BITS-3:0]),
        .sin_mag(sin_mag),
        .cos_mag(cos_mag)
    );

    // Quadrants one and three take the cosine column; cosine is the sine a quarter on.
    assign sin_sel = f3_quad_reg[0] ? cos_mag : sin_mag;
    assign cos_sel = f3_quad_reg[0] ? sin_mag : cos_mag;

    always_comb
    begin
        job.geo   = f3_geo_reg;
        job.sin_v = f3_quad_reg[1] ? -$signed({1'b0, sin_sel}) : $signed({1'b0, sin_sel});
        job.cos_v = (f3_quad_reg[1] ^ f3_quad_reg[0]) ? -$signed({1'b0, cos_sel})
                                                      : $signed({1'b0, cos_sel});
    end

    assign job_valid = f3_v_reg;

endmodule

/* rtl/sqvt_back.sv */
module sqvt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_pop,
    input  sqvt_pkg::job_t  job,
    output logic            out_valid,
    input  logic            out_ready,
    output sqvt_pkg::vert_t out_item
);

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [12:0]        u;
        logic [12:0]        v;
        logic [31:0]        color;
        logic [1:0]         corner;
        logic               last;
    } pass_t;

    logic [1:0] corner_reg;
    logic [1:0] corner_next;
    logic       b1_v_reg;
    logic       b1_v_next;
    logic       b2_v_reg;
    logic       b2_v_next;
    logic       b3_v_reg;
    logic       b3_v_next;
    logic       b1_ready;
    logic       b2_ready;
    logic       b3_ready;
    logic       b1_load;
    logic       dx;
    logic       dy;

    pass_t              pass_next;
    pass_t              b1_pass_reg;
    pass_t              b2_pass_reg;
    pass_t              b3_pass_reg;
    logic signed [37:0] lx_next;
    logic signed [37:0] ly_next;
    logic signed [37:0] b1_lx_reg;
    logic signed [37:0] b1_ly_reg;
    logic signed [15:0] b1_sin_reg;
    logic signed [15:0] b1_cos_reg;
    logic signed [53:0] b2_xc_reg;
    logic signed [53:0] b2_ys_reg;
    logic signed [53:0] b2_xs_reg;
    logic signed [53:0] b2_yc_reg;
    logic signed [54:0] sum_x;
    logic signed [54:0] sum_y;
    logic signed [32:0] b3_rx_reg;
    logic signed [32:0] b3_ry_reg;
    logic signed [33:0] abs_x;
    logic signed [33:0] abs_y;

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [23:0] r;
        priority if (!v[33] && (|v[32:23]))
        begin
            r = sqvt_pkg::POS_MAX;
        end
        else if (v[33] && !(&v[32:23]))
        begin
            r = sqvt_pkg::POS_MIN;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign b3_ready    = !b3_v_reg || out_ready;
    assign b2_ready    = !b2_v_reg || b3_ready;
    assign b1_ready    = !b1_v_reg || b2_ready;
    assign b1_load     = job_valid && b1_ready;
    assign job_pop     = b1_load && (corner_reg == sqvt_pkg::CORNER_BL);
    assign corner_next = b1_load ? corner_reg + 2'd1 : corner_reg;
    assign b1_v_next   = b1_ready ? job_valid : b1_v_reg;
    assign b2_v_next   = b2_ready ? b1_v_reg : b2_v_reg;
    assign b3_v_next   = b3_ready ? b2_v_reg : b3_v_reg;

    assign dx = (corner_reg == sqvt_pkg::CORNER_TR) || (corner_reg == sqvt_pkg::CORNER_BR);
    assign dy = (corner_reg == sqvt_pkg::CORNER_BR) || (corner_reg == sqvt_pkg::CORNER_BL);

    assign lx_next = 38'(job.geo.x0) + (dx ? 38'(job.geo.sw) : 38'sd0);
    assign ly_next = 38'(job.geo.y0) + (dy ? 38'(job.geo.sh) : 38'sd0);

    always_comb
    begin
        pass_next.px     = job.geo.px;
        pass_next.py     = job.geo.py;
        pass_next.u      = 13'(job.geo.tex_left) + (dx ? 13'(job.geo.tex_width) : 13'd0);
        pass_next.v      = 13'(job.geo.tex_top) + (dy ? 13'(job.geo.tex_height) : 13'd0);
        pass_next.color  = job.geo.color;
        pass_next.corner = corner_reg;
        pass_next.last   = (corner_reg == sqvt_pkg::CORNER_BL);
    end

    // Q.30 to Q.8 with the half rounded toward plus infinity.
    assign sum_x = 55'(b2_xc_reg) - 55'(b2_ys_reg) + 55'(sqvt_pkg::ROUND_HALF);
    assign sum_y = 55'(b2_xs_reg) + 55'(b2_yc_reg) + 55'(sqvt_pkg::ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= sqvt_pkg::CORNER_TL;
            b1_v_reg   <= 1'b0;
            b2_v_reg   <= 1'b0;
            b3_v_reg   <= 1'b0;
        end
        else
        begin
            corner_reg <= corner_next;
            b1_v_reg   <= b1_v_next;
            b2_v_reg   <= b2_v_next;
            b3_v_reg   <= b3_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_load)
        begin
            b1_lx_reg   <= lx_next;
            b1_ly_reg   <= ly_next;
            b1_sin_reg  <= job.sin_v;
            b1_cos_reg  <= job.cos_v;
            b1_pass_reg <= pass_next;
        end
        if (b2_ready && b1_v_reg)
        begin
            b2_xc_reg   <= b1_lx_reg * b1_cos_reg;
            b2_ys_reg   <= b1_ly_reg * b1_sin_reg;
            b2_xs_reg   <= b1_lx_reg * b1_sin_reg;
            b2_yc_reg   <= b1_ly_reg * b1_cos_reg;
            b2_pass_reg <= b1_pass_reg;
        end
        if (b3_ready && b2_v_reg)
        begin
            b3_rx_reg   <= $signed(sum_x[54:sqvt_pkg::ROUND_SHIFT]);
            b3_ry_reg   <= $signed(sum_y[54:sqvt_pkg::ROUND_SHIFT]);
            b3_pass_reg <= b2_pass_reg;
        end
    end

    assign abs_x = 34'(b3_rx_reg) + 34'(b3_pass_reg.px);
    assign abs_y = 34'(b3_ry_reg) + 34'(b3_pass_reg.py);

    always_comb
    begin
        out_item.vert_x     = sat24(abs_x);
        out_item.vert_y     = sat24(abs_y);
        out_item.tex_u      = b3_pass_reg.u;
        out_item.tex_v      = b3_pass_reg.v;
        out_item.vert_color = b3_pass_reg.color;
        out_item.corner     = b3_pass_reg.corner;
        out_item.last       = b3_pass_reg.last;
    end

    assign out_valid = b3_v_reg;

    a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
        b1_load |=> corner_reg == $past(corner_reg) + 2'd1)
        else $error("corner counter did not advance with a loaded corner");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        b3_v_reg && b3_pass_reg.last |-> b3_pass_reg.corner == sqvt_pkg::CORNER_BL)
        else $error("last flag on a corner other than bottom-left");

endmodule
